[hw/rtl/barograph_download_parser_defines.svh]
// Assertion macros for the barograph download parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BAROGRAPH_DOWNLOAD_PARSER_DEFINES_SVH
`define BAROGRAPH_DOWNLOAD_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdp assertion failed");

// Check a property on every clock edge, reset included.
`define BDP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bdp assertion failed");

`endif

[hw/rtl/bdp_pkg.sv]
// Package for the barograph download parser: field codes, sizes, constants.
// No dependencies.
package bdp_pkg;

  typedef enum logic [3:0] {
    FS_SYNC   = 4'd0,
    FS_FLIGHT = 4'd1,
    FS_LEN    = 4'd2,
    FS_SERIAL = 4'd3,
    FS_NAME   = 4'd4,
    FS_DATE   = 4'd5,
    FS_YEAR   = 4'd6,
    FS_MAX1   = 4'd7,
    FS_MAX2   = 4'd8,
    FS_CLIMB  = 4'd9,
    FS_DUR    = 4'd10,
    FS_IVAL   = 4'd11,
    FS_START  = 4'd12,
    FS_END    = 4'd13,
    FS_ALT    = 4'd14,
    FS_SPD    = 4'd15
  } field_e;

  localparam logic [3:0]         KindSyncErr = 4'd14;
  localparam logic [7:0]         SyncBase    = 8'h30;
  localparam logic [4:0]         SyncLen     = 5'd6;
  localparam logic signed [16:0] InitBudget  = 17'sd100;
  localparam logic signed [16:0] LenAdjust   = 17'sd2;

  // Byte count of each header or sample field.
  function automatic logic [4:0] field_bytes(field_e fs);
    logic [4:0] n;
    case (fs)
      FS_SYNC:   n = 5'd6;
      FS_FLIGHT: n = 5'd1;
      FS_NAME:   n = 5'd25;
      FS_IVAL:   n = 5'd1;
      FS_SPD:    n = 5'd1;
      default:   n = 5'd2;
    endcase
    return n;
  endfunction

  // Remaining budget as reported, floored at zero.
  function automatic logic [15:0] clamp_left(logic signed [16:0] b);
    logic [15:0] r;
    if (b <= 17'sd0) r = 16'd0;
    else r = b[15:0];
    return r;
  endfunction

endpackage

[hw/rtl/barograph_download_parser.sv]
// Barograph download parser top level: byte parser and result register.
// Depends on bdp_pkg and barograph_download_parser_defines.svh.
`include "barograph_download_parser_defines.svh"

// Takes one download byte (or a restart) per cycle: the field parser is a
// single state update between the input handshake and the result register,
// so a new word is accepted every cycle as long as the result register is
// empty or being drained. A word yields at most one result, on the cycle
// after it is accepted. After a sync error or an exhausted byte budget the
// parser ignores bytes until a restart word.
module barograph_download_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [15:0] value_o,
  output logic [31:0] time_offset_o,
  output logic [15:0] bytes_left_o,
  output logic        finished_o
);
  import bdp_pkg::*;

  field_e             field_q, field_d;
  logic [4:0]         byte_index_q, byte_index_d;
  logic [15:0]        assembly_q, assembly_d;
  logic               sync_bad_q, sync_bad_d;
  logic signed [16:0] budget_q, budget_d;
  logic [7:0]         log_interval_q, log_interval_d;
  logic [31:0]        elapsed_q, elapsed_d;
  logic               halted_q, halted_d;

  logic               out_valid_q;
  logic [3:0]         kind_q;
  logic [15:0]        value_q;
  logic [31:0]        time_offset_q;
  logic [15:0]        bytes_left_q;
  logic               finished_q;

  logic               in_fire;
  logic               res_valid;
  logic [3:0]         res_kind;
  logic [15:0]        res_value;
  logic [31:0]        res_toff;
  logic [15:0]        res_left;
  logic               res_fin;

  logic [4:0]         need;
  logic [4:0]         idx_inc;
  logic [15:0]        asm_new;
  logic [15:0]        fld_value;
  logic               bad_new;
  logic signed [16:0] budget_sub;
  logic signed [16:0] budget_new;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q        <= FS_SYNC;
      byte_index_q   <= '0;
      assembly_q     <= '0;
      sync_bad_q     <= 1'b0;
      budget_q       <= InitBudget;
      log_interval_q <= '0;
      elapsed_q      <= '0;
      halted_q       <= 1'b0;
    end else begin
      field_q        <= field_d;
      byte_index_q   <= byte_index_d;
      assembly_q     <= assembly_d;
      sync_bad_q     <= sync_bad_d;
      budget_q       <= budget_d;
      log_interval_q <= log_interval_d;
      elapsed_q      <= elapsed_d;
      halted_q       <= halted_d;
    end
  end

  always_comb begin
    field_d        = field_q;
    byte_index_d   = byte_index_q;
    assembly_d     = assembly_q;
    sync_bad_d     = sync_bad_q;
    budget_d       = budget_q;
    log_interval_d = log_interval_q;
    elapsed_d      = elapsed_q;
    halted_d       = halted_q;
    res_valid      = 1'b0;
    res_kind       = '0;
    res_value      = '0;
    res_toff       = '0;
    res_left       = '0;
    res_fin        = 1'b0;

    need       = field_bytes(field_q);
    idx_inc    = byte_index_q + 5'd1;
    asm_new    = {assembly_q[7:0], rx_byte_i};
    fld_value  = (need == 5'd1) ? {8'h00, rx_byte_i} : asm_new;
    bad_new    = sync_bad_q ||
                 (field_q == FS_SYNC && byte_index_q < SyncLen &&
                  rx_byte_i != (SyncBase + {5'b00000, byte_index_q[2:0]}));
    budget_sub = budget_q - signed'({12'b0, need});
    budget_new = (field_q == FS_LEN) ? (signed'({1'b0, fld_value}) - LenAdjust)
                                     : budget_sub;

    if (in_fire) begin
      if (op_i) begin
        // restart: back to the reset state, no result
        field_d        = FS_SYNC;
        byte_index_d   = '0;
        assembly_d     = '0;
        sync_bad_d     = 1'b0;
        budget_d       = InitBudget;
        log_interval_d = '0;
        elapsed_d      = '0;
        halted_d       = 1'b0;
      end else if (!halted_q) begin
        sync_bad_d = bad_new;
        if (idx_inc < need) begin
          assembly_d   = asm_new;
          byte_index_d = idx_inc;
        end else begin
          byte_index_d = '0;
          assembly_d   = '0;
          budget_d     = budget_new;
          if (field_q == FS_SYNC) begin
            if (bad_new) begin
              halted_d  = 1'b1;
              res_valid = 1'b1;
              res_kind  = KindSyncErr;
              res_left  = clamp_left(budget_new);
              res_fin   = 1'b1;
            end else begin
              field_d = FS_FLIGHT;
            end
          end else begin
            if (field_q == FS_IVAL)  log_interval_d = fld_value[7:0];
            if (field_q == FS_START) elapsed_d = '0;
            if (field_q == FS_ALT) begin
              res_toff  = elapsed_q;
              elapsed_d = elapsed_q + {24'b0, log_interval_q};
            end
            field_d  = (field_q == FS_SPD) ? FS_ALT : field_e'(field_q + 4'd1);
            res_fin  = (budget_new <= 17'sd0);
            if (res_fin) halted_d = 1'b1;
            // the skipped name never reports, even when it ends the budget
            res_valid = (field_q != FS_NAME);
            res_kind  = (field_q < FS_NAME) ? (field_q - 4'd1) : (field_q - 4'd2);
            res_value = fld_value;
            res_left  = clamp_left(budget_new);
          end
        end
      end
    end
  end

  // Result register: load on a new result, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q        <= res_kind;
      value_q       <= res_value;
      time_offset_q <= res_toff;
      bytes_left_q  <= res_left;
      finished_q    <= res_fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign value_o       = value_q;
  assign time_offset_o = time_offset_q;
  assign bytes_left_o  = bytes_left_q;
  assign finished_o    = finished_q;

  `BDP_ASSERT(a_restart_clears, in_fire && op_i |=> field_q == FS_SYNC && !halted_q)
  `BDP_ASSERT(a_halted_holds, in_fire && !op_i && halted_q |=> $stable(field_q) && halted_q)
  `BDP_ASSERT(a_finish_halts, out_valid_q && finished_q |-> halted_q)
  `BDP_ASSERT(a_empty_budget_finishes, out_valid_q && bytes_left_q == 16'd0 |-> finished_q)
  `BDP_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> in_ready_o)

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for barograph_download_parser: directed table, then random downloads.
// Depends on bdp_pkg and the parser RTL. Expected records: the table or a parser model kept here.
`timescale 1ns / 100ps

module tb_top;
  import bdp_pkg::*;

  localparam logic OpByte    = 1'b0;
  localparam logic OpRestart = 1'b1;

  localparam logic [3:0] KindFlight = 4'd0;
  localparam logic [3:0] KindLength = 4'd1;

  localparam int FieldLen [16] = '{6, 1, 2, 2, 25, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 1};
  localparam int IntervalPos   = 39;   // interval byte offset after the length field
  localparam int WordTarget    = 390;
  localparam int QuietLimit    = 4000;
  localparam int TailCycles    = 10;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [31:0] time_offset;
    logic [15:0] bytes_left;
    logic        finished;
  } record_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    logic        fixed;
    record_t     rec;
  } vector_t;

  localparam record_t NoRec = '0;

  localparam vector_t DirVec [22] = '{
    '{OpRestart, 8'hA5, 1'b0, NoRec},
    '{OpByte,    8'h30, 1'b0, NoRec},
    '{OpByte,    8'h31, 1'b0, NoRec},
    '{OpByte,    8'h32, 1'b0, NoRec},
    '{OpByte,    8'h33, 1'b0, NoRec},
    '{OpByte,    8'h34, 1'b0, NoRec},
    '{OpByte,    8'hFF, 1'b1, '{KindSyncErr, 16'd0, 32'd0, 16'd94, 1'b1}},
    '{OpByte,    8'h00, 1'b0, NoRec},   // halted: dropped
    '{OpRestart, 8'hFF, 1'b0, NoRec},
    '{OpByte,    8'h30, 1'b0, NoRec},
    '{OpByte,    8'h31, 1'b0, NoRec},
    '{OpByte,    8'h32, 1'b0, NoRec},
    '{OpByte,    8'h33, 1'b0, NoRec},
    '{OpByte,    8'h34, 1'b0, NoRec},
    '{OpByte,    8'h35, 1'b0, NoRec},
    '{OpByte,    8'hFF, 1'b1, '{KindFlight, 16'd255, 32'd0, 16'd93, 1'b0}},
    '{OpByte,    8'h00, 1'b0, NoRec},
    '{OpByte,    8'h00, 1'b1, '{KindLength, 16'd0, 32'd0, 16'd0, 1'b1}},
    '{OpByte,    8'h12, 1'b0, NoRec},   // halted: dropped
    '{OpRestart, 8'h00, 1'b0, NoRec},
    '{OpByte,    8'h30, 1'b0, NoRec},
    '{OpRestart, 8'h5A, 1'b0, NoRec}    // restart in the middle of sync
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        op_i        = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [3:0]  kind_o;
  logic [15:0] value_o;
  logic [31:0] time_offset_o;
  logic [15:0] bytes_left_o;
  logic        finished_o;

  // parser model state
  field_e      dl_field;
  logic [4:0]  dl_idx;
  logic [15:0] dl_shift;
  logic        dl_sync_bad;
  int          dl_budget;
  logic [7:0]  dl_ival;
  logic [31:0] dl_elapsed;
  logic        dl_halted;

  record_t records_due [$];
  int      errors     = 0;
  int      live_words = 0;
  int      idle_pct   = 0;
  int      stall_pct  = 0;
  int      quiet      = 0;

  barograph_download_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .time_offset_o(time_offset_o),
    .bytes_left_o (bytes_left_o),
    .finished_o   (finished_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void restart_decoder();
    dl_field    = FS_SYNC;
    dl_idx      = '0;
    dl_shift    = '0;
    dl_sync_bad = 1'b0;
    dl_budget   = int'(InitBudget);
    dl_ival     = '0;
    dl_elapsed  = '0;
    dl_halted   = 1'b0;
  endfunction

  // Advance the parser model by one word; return 1 when it yields a record.
  function automatic bit decode_byte(input logic op, input logic [7:0] b, output record_t rec);
    field_e      st;
    int          need;
    logic [15:0] val;
    rec = NoRec;
    if (op == OpRestart) begin
      restart_decoder();
      return 1'b0;
    end
    if (dl_halted) return 1'b0;
    st   = dl_field;
    need = FieldLen[st];
    if (st == FS_SYNC && dl_idx < SyncLen && b != SyncBase + 8'(dl_idx)) dl_sync_bad = 1'b1;
    dl_shift = {dl_shift[7:0], b};
    dl_idx   = dl_idx + 5'd1;
    if (int'(dl_idx) < need) return 1'b0;
    val       = (need == 1) ? {8'h00, b} : dl_shift;
    dl_idx    = '0;
    dl_shift  = '0;
    dl_budget = dl_budget - need;
    if (st == FS_SYNC && !dl_sync_bad) begin
      dl_field = FS_FLIGHT;
      return 1'b0;
    end
    if (st == FS_SYNC) begin
      dl_halted    = 1'b1;
      rec.kind     = KindSyncErr;
      rec.finished = 1'b1;
    end else begin
      if (st == FS_LEN) dl_budget = int'(val) - int'(LenAdjust);
      if (st == FS_IVAL) dl_ival = val[7:0];
      if (st == FS_START) dl_elapsed = '0;
      if (st == FS_ALT) begin
        rec.time_offset = dl_elapsed;
        dl_elapsed      = dl_elapsed + 32'(dl_ival);
      end
      dl_field     = (st == FS_SPD) ? FS_ALT : field_e'(st + 4'd1);
      rec.finished = (dl_budget <= 0);
      if (rec.finished) dl_halted = 1'b1;
      rec.kind  = (st < FS_NAME) ? st - 4'd1 : st - 4'd2;
      rec.value = val;
    end
    rec.bytes_left = (dl_budget <= 0) ? 16'd0 :
                     (dl_budget > 65535) ? 16'hFFFF : 16'(dl_budget);
    // the name field is swallowed even when it uses up the budget
    return st != FS_NAME;
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b, input logic fixed,
                           input record_t want);
    record_t rec;
    bit      has;
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpRestart || !dl_halted) live_words++;
    has = decode_byte(op, b, rec);
    if (fixed) records_due.push_back(want);
    else if (has) records_due.push_back(rec);
  endtask

  // Hold the sender until every pending record has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (records_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    record_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (records_due.size() == 0) begin
        $error("unexpected record: kind %0d value %0d", kind_o, value_o);
        errors++;
      end else begin
        want = records_due.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors++;
        end
        if (value_o !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value_o);
          errors++;
        end
        if (time_offset_o !== want.time_offset) begin
          $error("time_offset: expected %0d, got %0d", want.time_offset, time_offset_o);
          errors++;
        end
        if (bytes_left_o !== want.bytes_left) begin
          $error("bytes_left: expected %0d, got %0d", want.bytes_left, bytes_left_o);
          errors++;
        end
        if (finished_o !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, finished_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int         len;
    int         body;
    int         bad_pos;
    int         n_dl;
    int         pick;
    logic [7:0] b;
    restart_decoder();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirVec[i]) send_word(DirVec[i].op, DirVec[i].rx, DirVec[i].fixed, DirVec[i].rec);
    drain_results();

    n_dl = 0;
    while (live_words < WordTarget) begin
      case (n_dl % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (n_dl % 3 == 2) drain_results();
      n_dl++;
      send_word(OpRestart, 8'($urandom), 1'b0, NoRec);
      bad_pos = ($urandom_range(9, 0) == 0) ? $urandom_range(5, 0) : -1;
      for (int i = 0; i < SyncLen; i++) begin
        b = SyncBase + 8'(i);
        if (i == bad_pos) b = b ^ 8'($urandom_range(255, 1));
        send_word(OpByte, b, 1'b0, NoRec);
      end
      if (bad_pos >= 0) begin
        // a couple of bytes that the halted parser must drop
        repeat (2) send_word(OpByte, 8'($urandom), 1'b0, NoRec);
        continue;
      end
      send_word(OpByte, 8'($urandom), 1'b0, NoRec);
      pick = $urandom_range(99, 0);
      if (pick < 30) len = $urandom_range(46, 0);
      else if (pick < 85) len = $urandom_range(80, 47);
      else len = $urandom_range(65535, 81);
      send_word(OpByte, 8'(len >> 8), 1'b0, NoRec);
      send_word(OpByte, 8'(len), 1'b0, NoRec);
      // long downloads are cut short by the next restart
      body = (len > 80) ? $urandom_range(90, 20) : ((len > 2) ? len - 2 : 0) + $urandom_range(3, 0);
      for (int j = 0; j < body; j++) begin
        b = 8'($urandom);
        if (j == IntervalPos) begin
          case ($urandom_range(2, 0))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: ;
          endcase
        end
        if ($urandom_range(99, 0) < 2) begin
          send_word(OpRestart, b, 1'b0, NoRec);
          break;
        end
        send_word(OpByte, b, 1'b0, NoRec);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
